// ===== rtl/static_linked_list_engine_assert.svh =====
// Assertion macros shared by the checker of the static linked list engine.
// Depends on nothing; included by the checker file only.
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

// Property checked at every edge, reset included.
`define SLLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define SLLE_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/slle_pkg.sv =====
// Package of the static linked list engine: default sizes, stream field layout,
// operation and status codes and the sequencer state type. Depends on nothing.
package slle_pkg;

    // Default store sizes.
    localparam int SLLE_SLOTS        = 64;
    localparam int SLLE_ELEMENT_BITS = 16;

    // Field widths of one input transaction and one result transaction.
    localparam int SLLE_OP_BITS     = 1;
    localparam int SLLE_POS_BITS    = 6;
    localparam int SLLE_VALUE_BITS  = 16;
    localparam int SLLE_STATUS_BITS = 1;
    localparam int SLLE_LEN_BITS    = 6;

    // Packed stream widths, rounded up to whole bytes.
    localparam int SLLE_IN_USED  = SLLE_OP_BITS + SLLE_POS_BITS + SLLE_VALUE_BITS;
    localparam int SLLE_IN_BITS  = ((SLLE_IN_USED + 7) / 8) * 8;
    localparam int SLLE_OUT_USED = SLLE_STATUS_BITS + SLLE_LEN_BITS;
    localparam int SLLE_OUT_BITS = ((SLLE_OUT_USED + 7) / 8) * 8;
    localparam int SLLE_OUT_PAD  = SLLE_OUT_BITS - SLLE_OUT_USED;

    // Operation codes.
    localparam logic SLLE_OP_INSERT = 1'b0;
    localparam logic SLLE_OP_DELETE = 1'b1;

    // Status codes.
    localparam logic SLLE_STATUS_OK  = 1'b0;
    localparam logic SLLE_STATUS_ERR = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_INS_A,
        ST_INS_B,
        ST_DEL_A,
        ST_DEL_B,
        ST_DONE
    } t_slle_state;

endpackage

// ===== rtl/static_linked_list_engine.sv =====
// Static linked list engine: a cursor list in a link memory and a value memory; uses slle_pkg.
// An accepted transaction is checked first; a rejected one goes straight to the result, else the walk
// follows pos-1 links (the length on append) and then updates the links; the walk reads one link per cycle.
// No new transaction is taken until the result of the last one is loaded into the result register.
// Reset (synchronous, active low) drops any result and starts a pass that rebuilds the free
// chain in the link memory; no input is taken until it ends.
module static_linked_list_engine
    import slle_pkg::*;
#(
    parameter int SLOTS        = SLLE_SLOTS,
    parameter int ELEMENT_BITS = SLLE_ELEMENT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // Fields from bit 0: operation[0], position[6:1], value[22:7], zero pad[23].
    input  logic [SLLE_IN_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // Fields from bit 0: status[0], length[6:1], zero pad[7].
    output logic [SLLE_OUT_BITS-1:0] m_axis_tdata
);

    localparam int LW = $clog2(SLOTS);
    localparam int CW = (LW > SLLE_POS_BITS) ? LW : SLLE_POS_BITS;
    localparam logic [LW-1:0] HEAD_SLOT = LW'(SLOTS - 1);
    localparam logic [LW-1:0] LAST_FREE = LW'(SLOTS - 2);

    // Registers and their next values.
    t_slle_state                r_state, n_state;
    logic [LW-1:0]              r_clr, n_clr;
    logic                       r_op, n_op;
    logic [SLLE_POS_BITS-1:0]   r_pos, n_pos;
    logic [SLLE_VALUE_BITS-1:0] r_value, n_value;
    logic [LW-1:0]              r_len, n_len;
    logic [LW-1:0]              r_free, n_free;
    logic [LW-1:0]              r_prev, n_prev;
    logic [LW-1:0]              r_nxt, n_nxt;
    logic [LW-1:0]              r_cnt, n_cnt;
    logic                       r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_status, n_out_status;
    logic [SLLE_LEN_BITS-1:0]   r_out_len, n_out_len;

    // Memories.
    logic [LW-1:0]           r_link_mem [SLOTS];
    logic [ELEMENT_BITS-1:0] r_elem_mem [SLOTS];
    logic [LW-1:0]           r_rd_data;

    // Memory port controls.
    logic                    w_we;
    logic [LW-1:0]           w_waddr;
    logic [LW-1:0]           w_wdata;
    logic [LW-1:0]           w_raddr;
    logic                    w_elem_we;

    // Shared datapath terms.
    logic                    w_in_acc;
    logic                    w_out_load;
    logic [LW-1:0]           w_link;
    logic [CW-1:0]           w_pos_ext;
    logic [CW-1:0]           w_len_ext;
    logic                    w_ins_ok;
    logic                    w_del_ok;
    logic [LW-1:0]           w_steps;
    logic [LW-1:0]           w_clr_init;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // A link read back at or above SLOTS counts as the end of a chain.
    assign w_link = ({1'b0, r_rd_data} >= (LW + 1)'(SLOTS)) ? '0 : r_rd_data;

    // Position checks, compared at a common width.
    assign w_pos_ext = CW'(r_pos);
    assign w_len_ext = CW'(r_len);
    assign w_ins_ok  = (w_pos_ext <= w_len_ext) && (r_free != '0);
    assign w_del_ok  = (r_pos != '0) && (w_pos_ext <= w_len_ext);
    assign w_steps   = ((r_op == SLLE_OP_INSERT) && (r_pos == '0)) ? r_len
                                                                   : LW'(w_pos_ext - CW'(1));

    // Initial free chain: each slot points at the next, the last free slot ends it.
    assign w_clr_init = (r_clr < LAST_FREE) ? LW'(r_clr + 1'b1) : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == HEAD_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((r_op == SLLE_OP_INSERT) ? w_ins_ok : w_del_ok) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_WALK: begin
                if (r_cnt == '0) begin
                    if (r_op == SLLE_OP_INSERT) begin
                        n_state = ST_INS_A;
                    end else if (w_link == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DEL_A;
                    end
                end
            end
            ST_INS_A: n_state = ST_INS_B;
            ST_INS_B: n_state = ST_DONE;
            ST_DEL_A: n_state = ST_DEL_B;
            ST_DEL_B: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory controls for each state.
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_pos        = r_pos;
        n_value      = r_value;
        n_len        = r_len;
        n_free       = r_free;
        n_prev       = r_prev;
        n_nxt        = r_nxt;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_valid  = r_out_valid && !m_axis_tready;
        s_axis_tready = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_prev;
        w_wdata      = r_free;
        w_raddr      = r_prev;
        w_elem_we    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = w_clr_init;
                n_clr   = LW'(r_clr + 1'b1);
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_acc) begin
                    n_op    = s_axis_tdata[0];
                    n_pos   = s_axis_tdata[SLLE_POS_BITS:1];
                    n_value = s_axis_tdata[SLLE_IN_USED-1:SLLE_POS_BITS+1];
                end
            end
            ST_DECIDE: begin
                // Start the walk at the used-list head slot.
                w_raddr  = HEAD_SLOT;
                n_prev   = HEAD_SLOT;
                n_cnt    = w_steps;
                n_status = ((r_op == SLLE_OP_INSERT) ? w_ins_ok : w_del_ok)
                           ? SLLE_STATUS_OK : SLLE_STATUS_ERR;
            end
            ST_WALK: begin
                if (r_cnt == '0) begin
                    // The slot after the predecessor; for delete, fetch its link.
                    n_nxt   = w_link;
                    w_raddr = w_link;
                    if ((r_op == SLLE_OP_DELETE) && (w_link == '0)) begin
                        n_status = SLLE_STATUS_ERR;
                    end
                end else begin
                    n_prev  = w_link;
                    w_raddr = w_link;
                    n_cnt   = LW'(r_cnt - 1'b1);
                end
            end
            ST_INS_A: begin
                // New cell points at the successor; its old link is read in the same cycle.
                w_we    = 1'b1;
                w_waddr = r_free;
                w_wdata = r_nxt;
                w_raddr = r_free;
            end
            ST_INS_B: begin
                w_we      = 1'b1;
                w_waddr   = r_prev;
                w_wdata   = r_free;
                w_elem_we = 1'b1;
                n_free    = w_link;
                n_len     = LW'(r_len + 1'b1);
            end
            ST_DEL_A: begin
                // Predecessor skips the victim.
                w_we    = 1'b1;
                w_waddr = r_prev;
                w_wdata = w_link;
            end
            ST_DEL_B: begin
                // Victim goes to the front of the free list.
                w_we    = 1'b1;
                w_waddr = r_nxt;
                w_wdata = r_free;
                n_free  = r_nxt;
                n_len   = LW'(r_len - 1'b1);
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_len    = w_len_ext[SLLE_LEN_BITS-1:0];
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_len       <= '0;
            r_free      <= LW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_len       <= n_len;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pos        <= n_pos;
        r_value      <= n_value;
        r_prev       <= n_prev;
        r_nxt        <= n_nxt;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
    end

    // Link memory: one write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_link_mem[w_raddr];
    end

    // Value memory: written on insert.
    always_ff @(posedge i_clk) begin
        if (w_elem_we) begin
            r_elem_mem[r_free] <= ELEMENT_BITS'(r_value);
        end
    end

    // Result stream.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{SLLE_OUT_PAD{1'b0}}, r_out_len, r_out_status};

endmodule

// ===== rtl/slle_checker.sv =====
// Port checker for the static linked list engine, bound to the top level.
// Depends on slle_pkg and static_linked_list_engine_assert.svh.
`include "static_linked_list_engine_assert.svh"

module slle_checker
    import slle_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_tvalid,
    input logic                     i_s_tready,
    input logic                     i_m_tvalid,
    input logic                     i_m_tready,
    input logic [SLLE_OUT_BITS-1:0] i_m_tdata
);

    // Reset starts the free chain rebuild, so no input is taken right after it.
    `SLLE_ASSERT_ALWAYS(a_rst_not_ready, i_clk, !i_rst_n |=> !i_s_tready, "ready after reset")

    // Reset drops any pending result.
    `SLLE_ASSERT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n |=> !i_m_tvalid, "result after reset")

    // An accepted transaction keeps the block busy while it is decided and in the state that follows.
    `SLLE_ASSERT_RUN(a_busy_after_accept, i_clk, i_rst_n,
                     (i_s_tvalid && i_s_tready) |=> !i_s_tready ##1 !i_s_tready,
                     "input taken while busy")

    // A stalled result holds its value.
    `SLLE_ASSERT_RUN(a_out_hold, i_clk, i_rst_n,
                     (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)),
                     "stalled result changed")

endmodule

bind static_linked_list_engine slle_checker u_slle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
